/* rtl/ppmc_pkg.sv */
package ppmc_pkg;

    // store geometry
    localparam int MAX_LEN     = 1024;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int POS_W       = ADDR_W + 1;
    localparam int LETTER_W    = 2;

    // pattern geometry
    localparam int MAX_PATTERN = 10;
    localparam int PATTERN_W   = MAX_PATTERN * LETTER_W;
    localparam int PLEN_W      = 4;
    localparam int PHASE_W     = 4;

    // result width
    localparam int COUNT_W     = 11;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // pattern letter at a given phase, letters beyond the field read as A
    function automatic logic [LETTER_W-1:0] pattern_letter(
        input logic [PATTERN_W-1:0] pat,
        input logic [PHASE_W-1:0]   phase
    );
        logic [LETTER_W-1:0] result;
        result = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (phase == PHASE_W'(i)) begin
                result = pat[i*LETTER_W +: LETTER_W];
            end
        end
        return result;
    endfunction

endpackage

/* rtl/ppmc_ram.sv */
module ppmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/periodic_pattern_match_counter_core.sv */
// write word: s_ready stays high, one write per cycle while no query is busy.
// query word: the letter store is walked one position per cycle through one
// ram read port and one letter comparator; a query over N stored positions
// goes through the scan, drain and done states (only done when N is zero)
// and keeps s_ready low until its result is loaded into the output register.
// reset clears the sequencer and the result valid flag; the letter store is
// not cleared and holds undefined letters until written.
module periodic_pattern_match_counter_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [ppmc_pkg::POS_W-1:0]            s_position,
    input  logic [ppmc_pkg::LETTER_W-1:0]         s_letter,
    input  logic [ppmc_pkg::POS_W-1:0]            s_range_low,
    input  logic [ppmc_pkg::POS_W-1:0]            s_range_high,
    input  logic [ppmc_pkg::PATTERN_W-1:0]        s_pattern,
    input  logic [ppmc_pkg::PLEN_W-1:0]           s_pattern_length,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ppmc_pkg::COUNT_W-1:0]          m_match_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [ppmc_pkg::POS_W-1:0]      pos_reg;
    logic [ppmc_pkg::POS_W-1:0]      last_reg;
    logic [ppmc_pkg::PHASE_W-1:0]    phase_reg;
    logic [ppmc_pkg::PHASE_W-1:0]    plen_reg;
    logic [ppmc_pkg::PATTERN_W-1:0]  pattern_reg;
    logic [ppmc_pkg::LETTER_W-1:0]   expect_reg;
    logic                            cmp_valid_reg;
    logic [ppmc_pkg::COUNT_W-1:0]    count_reg;
    logic                            m_valid_reg;
    logic [ppmc_pkg::COUNT_W-1:0]    m_match_count_reg;

    logic                            s_accept;
    logic                            ram_we;
    logic [ppmc_pkg::ADDR_W-1:0]     ram_waddr;
    logic                            ram_re;
    logic [ppmc_pkg::ADDR_W-1:0]     ram_raddr;
    logic [ppmc_pkg::LETTER_W-1:0]   ram_rdata;
    logic [ppmc_pkg::PHASE_W-1:0]    plen_sat;
    logic [ppmc_pkg::POS_W-1:0]      first_pos;
    logic [ppmc_pkg::POS_W-1:0]      last_pos;
    logic [ppmc_pkg::PHASE_W-1:0]    first_phase;
    logic                            query_busy;
    logic [ppmc_pkg::PHASE_W-1:0]    phase_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // write word goes straight into the store when the position is legal
    assign ram_we    = s_accept && (s_operation == ppmc_pkg::OP_WRITE)
                       && (s_position != '0)
                       && (s_position <= ppmc_pkg::POS_W'(ppmc_pkg::MAX_LEN));
    assign ram_waddr = ppmc_pkg::ADDR_W'(s_position - ppmc_pkg::POS_W'(1));

    // scan read address
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_raddr = ppmc_pkg::ADDR_W'(pos_reg - ppmc_pkg::POS_W'(1));

    // query setup: clip range to the store and saturate pattern length
    always_comb begin
        plen_sat = (s_pattern_length > ppmc_pkg::PLEN_W'(ppmc_pkg::MAX_PATTERN))
                   ? ppmc_pkg::PHASE_W'(ppmc_pkg::MAX_PATTERN)
                   : ppmc_pkg::PHASE_W'(s_pattern_length);
        first_pos = (s_range_low == '0) ? ppmc_pkg::POS_W'(1) : s_range_low;
        last_pos  = (s_range_high > ppmc_pkg::POS_W'(ppmc_pkg::MAX_LEN))
                    ? ppmc_pkg::POS_W'(ppmc_pkg::MAX_LEN) : s_range_high;
        // phase is one when the range starts at position zero, unless length is one
        first_phase = ((s_range_low == '0) && (plen_sat != ppmc_pkg::PHASE_W'(1)))
                      ? ppmc_pkg::PHASE_W'(1) : '0;
        query_busy = (plen_sat != '0) && (s_range_low <= s_range_high)
                     && (first_pos <= last_pos);
    end

    // phase wraps at the pattern length
    assign phase_next = (phase_reg + ppmc_pkg::PHASE_W'(1) == plen_reg)
                        ? '0 : phase_reg + ppmc_pkg::PHASE_W'(1);

    // sequencer, scan counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // drop the result word once taken, unless a new one is loaded below
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            // compare the letter read in the previous cycle
            cmp_valid_reg <= (state_reg == ST_SCAN);
            if (cmp_valid_reg && (ram_rdata == expect_reg)) begin
                count_reg <= count_reg + ppmc_pkg::COUNT_W'(1);
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_operation == ppmc_pkg::OP_QUERY)) begin
                        pos_reg     <= first_pos;
                        last_reg    <= last_pos;
                        phase_reg   <= first_phase;
                        plen_reg    <= plen_sat;
                        pattern_reg <= s_pattern;
                        count_reg   <= '0;
                        state_reg   <= query_busy ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    expect_reg <= ppmc_pkg::pattern_letter(pattern_reg, phase_reg);
                    pos_reg    <= pos_reg + ppmc_pkg::POS_W'(1);
                    phase_reg  <= phase_next;
                    if (pos_reg == last_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_match_count_reg <= count_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_count = m_match_count_reg;

    // letter store
    ppmc_ram #(
        .WIDTH (ppmc_pkg::LETTER_W),
        .DEPTH (ppmc_pkg::MAX_LEN)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_letter),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* verif/tb.sv */
module tb;

    localparam int   MAX_LEN     = ppmc_pkg::MAX_LEN;
    localparam int   MAX_PATTERN = ppmc_pkg::MAX_PATTERN;
    localparam int   POS_W       = ppmc_pkg::POS_W;
    localparam int   LETTER_W    = ppmc_pkg::LETTER_W;
    localparam int   PATTERN_W   = ppmc_pkg::PATTERN_W;
    localparam int   PLEN_W      = ppmc_pkg::PLEN_W;
    localparam int   COUNT_W     = ppmc_pkg::COUNT_W;
    localparam logic OP_WRITE    = ppmc_pkg::OP_WRITE;
    localparam logic OP_QUERY    = ppmc_pkg::OP_QUERY;

    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = MAX_LEN + 64;
    localparam int RANDOM_WORDS = 366;

    // loaded windows at both ends of the store, queries only read these
    localparam int WINDOW     = 96;
    localparam int HIGH_START = MAX_LEN - WINDOW + 1;

    typedef struct packed {
        logic                 op;
        logic [POS_W-1:0]     position;
        logic [LETTER_W-1:0]  letter;
        logic [POS_W-1:0]     range_low;
        logic [POS_W-1:0]     range_high;
        logic [PATTERN_W-1:0] pattern;
        logic [PLEN_W-1:0]    pattern_length;
    } ppmc_word_t;

    // letter store mirror and queue of pending match counts
    class match_count_board;
        logic [LETTER_W-1:0] letters [1:MAX_LEN];
        logic [COUNT_W-1:0]  pending_counts [$];
        int                  mismatches = 0;

        // cyclic pattern count over the stored letters
        function logic [COUNT_W-1:0] count_matches(ppmc_word_t w);
            int unsigned eff_len, lo, hi, scan_start, scan_end, phase, total;
            logic [LETTER_W-1:0] want_letter;
            eff_len = (w.pattern_length > MAX_PATTERN) ? MAX_PATTERN : w.pattern_length;
            lo = w.range_low;
            hi = w.range_high;
            total = 0;
            if (eff_len != 0 && lo <= hi) begin
                scan_start = (lo < 1) ? 1 : lo;
                scan_end = (hi > MAX_LEN) ? MAX_LEN : hi;
                phase = (scan_start - lo) % eff_len;
                for (int unsigned p = scan_start; p <= scan_end; p++) begin
                    want_letter = (phase < MAX_PATTERN) ?
                                  w.pattern[phase*LETTER_W +: LETTER_W] : '0;
                    if (letters[p] == want_letter) total++;
                    phase++;
                    if (phase == eff_len) phase = 0;
                end
            end
            if (total > (2**COUNT_W) - 1) total = (2**COUNT_W) - 1;
            return COUNT_W'(total);
        endfunction

        // accepted input word: update store or queue a count
        function void note_word(ppmc_word_t w);
            if (w.op == OP_WRITE) begin
                if (w.position >= 1 && w.position <= MAX_LEN) begin
                    letters[w.position] = w.letter;
                end
            end else begin
                pending_counts.push_back(count_matches(w));
            end
        endfunction

        // accepted result word against the oldest pending count
        function void check_count(logic [COUNT_W-1:0] got);
            logic [COUNT_W-1:0] want;
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected match_count %0d", got);
                return;
            end
            want = pending_counts.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("match_count mismatch: expected %0d got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_operation = OP_WRITE;
    logic [POS_W-1:0]     s_position = '0;
    logic [LETTER_W-1:0]  s_letter = '0;
    logic [POS_W-1:0]     s_range_low = '0;
    logic [POS_W-1:0]     s_range_high = '0;
    logic [PATTERN_W-1:0] s_pattern = '0;
    logic [PLEN_W-1:0]    s_pattern_length = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COUNT_W-1:0]   m_match_count;

    match_count_board board;
    bit               quiet = 1'b0;
    int               stall_cycles = 0;

    periodic_pattern_match_counter_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_position       (s_position),
        .s_letter         (s_letter),
        .s_range_low      (s_range_low),
        .s_range_high     (s_range_high),
        .s_pattern        (s_pattern),
        .s_pattern_length (s_pattern_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_count    (m_match_count)
    );

    always #4 aclk = ~aclk;

    // result side: check accepted words, random back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_count(m_match_count);
        m_ready <= quiet || ($urandom_range(0, 99) >= 12);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // write word, query fields filled with junk
    function automatic ppmc_word_t write_word(int position, int letter);
        ppmc_word_t w;
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        w = junk[$bits(ppmc_word_t)-1:0];
        w.op = OP_WRITE;
        w.position = POS_W'(position);
        w.letter = LETTER_W'(letter);
        return w;
    endfunction

    // query word, write fields filled with junk
    function automatic ppmc_word_t query_word(int lo, int hi, int pat, int plen);
        ppmc_word_t w;
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        w = junk[$bits(ppmc_word_t)-1:0];
        w.op = OP_QUERY;
        w.range_low = POS_W'(lo);
        w.range_high = POS_W'(hi);
        w.pattern = PATTERN_W'(pat);
        w.pattern_length = PLEN_W'(plen);
        return w;
    endfunction

    // random mix: window and stray writes, window queries, empty and above-store ranges
    function automatic ppmc_word_t random_word();
        int pick, lo, hi, plen;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 9) == 0) return write_word($urandom_range(0, 2047),
                                                             $urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) begin
                return write_word($urandom_range(1, WINDOW), $urandom_range(0, 3));
            end
            return write_word($urandom_range(HIGH_START, MAX_LEN), $urandom_range(0, 3));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            lo = $urandom_range(0, WINDOW);
            hi = lo + $urandom_range(0, 40);
            if (hi > WINDOW) hi = WINDOW;
        end else if (pick < 70) begin
            lo = $urandom_range(HIGH_START, MAX_LEN);
            hi = lo + $urandom_range(0, 1100);
            if (hi > 2047) hi = 2047;
        end else if (pick < 85) begin
            lo = $urandom_range(1, 2047);
            hi = $urandom_range(0, lo - 1);
        end else begin
            lo = $urandom_range(MAX_LEN + 1, 2047);
            hi = $urandom_range(0, 2047);
        end
        plen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, MAX_PATTERN)
                                             : $urandom_range(0, 15);
        return query_word(lo, hi, $urandom_range(0, (1 << PATTERN_W) - 1), plen);
    endfunction

    // hand one word to the block, with random gaps before it
    task automatic send_word(ppmc_word_t w);
        while (!quiet && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= w.op;
        s_position <= w.position;
        s_letter <= w.letter;
        s_range_low <= w.range_low;
        s_range_high <= w.range_high;
        s_pattern <= w.pattern;
        s_pattern_length <= w.pattern_length;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_word(w);
    endtask

    // hold the sender until every pending count has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending_counts.size() != 0);
    endtask

    initial begin
        int ref_letter;
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // short store, ignored writes, special query shapes
        send_word(write_word(1, 0));
        send_word(write_word(2, 1));
        send_word(write_word(3, 2));
        send_word(write_word(4, 3));
        send_word(write_word(5, 3));
        send_word(write_word(0, 3));
        send_word(write_word(1025, 0));
        send_word(write_word(2047, 1));
        send_word(query_word(1, 5, 'hE4, 4));
        send_word(query_word(5, 4, 'hE4, 4));
        send_word(query_word(1, 5, 'hE4, 0));
        send_word(query_word(1, 5, 'hE4, 15));
        send_word(query_word(0, 5, 'hFFFFF, 2));
        send_word(query_word(1025, 2047, 'h55555, 10));
        send_word(query_word(0, 0, 'h0, 1));
        send_word(query_word(1, 5, 'h3, 1));
        wait_drained();

        // load both windows before any wider query
        for (int p = 1; p <= WINDOW; p++) begin
            send_word(write_word(p, $urandom_range(0, 3)));
        end
        for (int p = HIGH_START; p <= MAX_LEN; p++) begin
            send_word(write_word(p, $urandom_range(0, 3)));
        end

        // full-window and edge-position queries
        send_word(query_word(0, WINDOW, 'hFFFFF, 10));
        send_word(query_word(1, WINDOW, 'h0, 1));
        send_word(query_word(HIGH_START, 2047, 'hAAAAA, 7));
        send_word(query_word(MAX_LEN, MAX_LEN, 'hAAAAA, 3));
        ref_letter = $urandom_range(0, 3);
        send_word(write_word(MAX_LEN, ref_letter));
        send_word(query_word(MAX_LEN, MAX_LEN, ref_letter, 1));
        wait_drained();

        // random words, one stretch without gaps, one full drain midway
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            quiet = (i >= 120 && i < 200);
            if (i == 260) wait_drained();
            send_word(random_word());
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        // let the last counts come, then watch for strays
        while (board.pending_counts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.pending_counts.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
